### hw/rtl/qrs_pkg.sv
// Shared widths, status codes and pipeline side-band types of the quadratic root solver.
package qrs_pkg;

	localparam int CW    = 32;              // coefficient and root width
	localparam int FB    = 16;              // fraction bits
	localparam int EW    = 16;              // epsilon register width
	localparam int DW    = 2 * CW + 3;      // discriminant magnitude width
	localparam int SW    = (DW + 1) / 2;    // square root width
	localparam int RADW  = 2 * SW;          // radicand width, even
	localparam int SREMW = SW + 2;          // square root remainder width
	localparam int NW    = SW + 2;          // numerator width, signed
	localparam int DENW  = CW + 1;          // denominator magnitude width
	localparam int DVW   = NW + FB;         // dividend and quotient width

	localparam logic [DVW-1:0] LIM_POS = DVW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [DVW-1:0] LIM_NEG = DVW'(64'd1 << (CW - 1));

	typedef enum logic [2:0] {
		ST_TWO      = 3'd0,
		ST_DOUBLE   = 3'd1,
		ST_NONE     = 3'd2,
		ST_LIN_ONE  = 3'd3,
		ST_LIN_NONE = 3'd4,
		ST_ALL      = 3'd5
	} status_t;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		logic                 cbig;
		status_t              status;
	} sq_side_t;

	typedef struct packed {
		status_t status;
		logic    neg1;
		logic    neg2;
	} dv_side_t;

endpackage

### hw/rtl/quadratic_root_solver_top.sv
// Top level of the quadratic root solver: coefficient pipeline, root and quotient units.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  s       | in        | s_tvalid / s_tready        | s_tdata: coef_square, coef_linear, coef_constant
//  m       | out       | m_tvalid / m_tready        | m_tdata: root_one, root_two; m_tuser: status, ovf
//  cfg     | in        | cfg_valid / cfg_ready      | cfg_data: epsilon
//
// One word is taken per cycle while the pipeline is not held; the path runs through three front stages, 34 square root
// stages, one numerator stage, 52 divider stages and the output register.
// arst_n clears every valid bit and sets epsilon to 1; data registers are not reset.
// All stages hold together while the output register is full and m_tready is low.
module quadratic_root_solver_top import qrs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,   // coef_square[31:0], coef_linear[63:32], coef_constant[95:64]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,   // root_one[31:0], root_two[63:32]
	output logic [3:0]    m_tuser,   // solution_status[2:0], overflow[3]
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [EW-1:0] cfg_data
);

	logic          en;
	logic [EW-1:0] eps_q;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EW'(1);
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// stage 1: take the word
	logic                 v_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_tdata[31:0];
			b_s1 <= s_tdata[63:32];
			c_s1 <= s_tdata[95:64];
		end
	end

	// stage 2: magnitudes, tolerance tests, products
	logic [CW-1:0] ma, mb, mc, eps_x;

	always_comb begin
		ma    = a_s1[CW-1] ? CW'(-a_s1) : CW'(a_s1);
		mb    = b_s1[CW-1] ? CW'(-b_s1) : CW'(b_s1);
		mc    = c_s1[CW-1] ? CW'(-c_s1) : CW'(c_s1);
		eps_x = CW'(eps_q);
	end

	logic                 v_s2;
	logic [2*CW-1:0]      b2_s2, pac_s2;
	logic signed [CW-1:0] a_s2, b_s2, c_s2;
	logic                 abig_s2, bbig_s2, cbig_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b2_s2   <= mb * mb;
			pac_s2  <= ma * mc;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			abig_s2 <= (ma > eps_x);
			bbig_s2 <= (mb > eps_x);
			cbig_s2 <= (mc > eps_x);
		end
	end

	// stage 3: discriminant and classification
	logic [DW-1:0] b2x, px, dmag, epsd;
	logic          dneg;
	status_t       st;

	always_comb begin
		b2x  = DW'(b2_s2);
		px   = DW'({pac_s2, 2'b00});
		epsd = DW'({eps_q, {FB{1'b0}}});
		dneg = 1'b0;
		if (a_s2[CW-1] != c_s2[CW-1]) begin
			dmag = b2x + px;
		end else if (b2x >= px) begin
			dmag = b2x - px;
		end else begin
			dmag = px - b2x;
			dneg = 1'b1;
		end
		priority if (!abig_s2) begin
			if (bbig_s2) st = ST_LIN_ONE;
			else if (cbig_s2) st = ST_LIN_NONE;
			else st = ST_ALL;
		end else if (!dneg && dmag > epsd) begin
			st = ST_TWO;
		end else if (dmag <= epsd) begin
			st = ST_DOUBLE;
		end else begin
			st = ST_NONE;
		end
	end

	logic            v_s3;
	logic [RADW-1:0] rad_s3;
	sq_side_t        side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3         <= RADW'(dmag);
			side_s3.a      <= a_s2;
			side_s3.b      <= b_s2;
			side_s3.c      <= c_s2;
			side_s3.cbig   <= cbig_s2;
			side_s3.status <= st;
		end
	end

	logic          sq_valid;
	logic [SW-1:0] sq_root;
	sq_side_t      sq_side;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// stage 4: numerators and denominator
	logic signed [NW-1:0]   bx, cx, sx, n1, n2;
	logic signed [DENW-1:0] dn;

	always_comb begin
		bx = {{(NW-CW){sq_side.b[CW-1]}}, sq_side.b};
		cx = {{(NW-CW){sq_side.c[CW-1]}}, sq_side.c};
		sx = {2'b00, sq_root};
		unique case (sq_side.status)
			ST_TWO: begin
				n1 = -bx + sx;
				n2 = -bx - sx;
				dn = {sq_side.a, 1'b0};
			end
			ST_DOUBLE: begin
				n1 = -bx;
				n2 = -bx;
				dn = {sq_side.a, 1'b0};
			end
			ST_LIN_ONE: begin
				n1 = sq_side.cbig ? -cx : '0;
				n2 = n1;
				dn = {sq_side.b[CW-1], sq_side.b};
			end
			default: begin
				n1 = '0;
				n2 = '0;
				dn = DENW'(1);
			end
		endcase
	end

	logic            v_s4;
	logic [NW-1:0]   n1m_s4, n2m_s4;
	logic [DENW-1:0] dnm_s4;
	dv_side_t        side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1m_s4         <= n1[NW-1] ? NW'(-n1) : NW'(n1);
			n2m_s4         <= n2[NW-1] ? NW'(-n2) : NW'(n2);
			dnm_s4         <= dn[DENW-1] ? DENW'(-dn) : DENW'(dn);
			side_s4.status <= sq_side.status;
			side_s4.neg1   <= n1[NW-1] ^ dn[DENW-1];
			side_s4.neg2   <= n2[NW-1] ^ dn[DENW-1];
		end
	end

	logic           dv_valid;
	logic [DVW-1:0] q1, q2;
	dv_side_t       dv_side;

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num1      (n1m_s4),
		.num2      (n2m_s4),
		.den       (dnm_s4),
		.in_side   (side_s4),
		.out_valid (dv_valid),
		.quo1      (q1),
		.quo2      (q2),
		.out_side  (dv_side)
	);

	// saturate and restore the sign; bit CW of the result is the overflow flag
	function automatic logic [CW:0] sat_root(input logic [DVW-1:0] q, input logic neg);
		logic [DVW-1:0] lim;
		logic [DVW-1:0] m;
		logic           ovf;
		lim = neg ? LIM_NEG : LIM_POS;
		ovf = (q > lim);
		m   = ovf ? lim : q;
		return {ovf, (neg && m != '0) ? CW'(-m) : CW'(m)};
	endfunction

	logic [CW:0] r1, r2;

	always_comb begin
		r1 = sat_root(q1, dv_side.neg1);
		r2 = sat_root(q2, dv_side.neg2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {r2[CW-1:0], r1[CW-1:0]};
			m_tuser <= {r1[CW] | r2[CW], dv_side.status};
		end
	end

endmodule

### hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt import qrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [RADW-1:0] rad,
	input  sq_side_t        in_side,
	output logic            out_valid,
	output logic [SW-1:0]   root,
	output sq_side_t        out_side
);

	logic              v_s   [SW+1];
	logic [RADW-1:0]   rad_s [SW+1];
	logic [SREMW-1:0]  rem_s [SW+1];
	logic [SW-1:0]     q_s   [SW+1];
	sq_side_t          sd_s  [SW+1];

	assign v_s[0]   = in_valid;
	assign rad_s[0] = rad;
	assign rem_s[0] = '0;
	assign q_s[0]   = '0;
	assign sd_s[0]  = in_side;

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic [SREMW+1:0] t;
		logic [SREMW+1:0] trial;
		logic             ge;

		always_comb begin
			t     = {rem_s[k], rad_s[k][RADW-1 -: 2]};
			trial = {2'b00, q_s[k], 2'b01};
			ge    = (t >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_s[k] << 2;
				rem_s[k+1] <= ge ? SREMW'(t - trial) : SREMW'(t);
				q_s[k+1]   <= {q_s[k][SW-2:0], ge};
				sd_s[k+1]  <= sd_s[k];
			end
		end
	end

	assign out_valid = v_s[SW];
	assign root      = q_s[SW];
	assign out_side  = sd_s[SW];

endmodule

### hw/rtl/qrs_div.sv
// Pipelined restoring divider, two numerator lanes over one shared denominator.
module qrs_div import qrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NW-1:0]   num1,
	input  logic [NW-1:0]   num2,
	input  logic [DENW-1:0] den,
	input  dv_side_t        in_side,
	output logic            out_valid,
	output logic [DVW-1:0]  quo1,
	output logic [DVW-1:0]  quo2,
	output dv_side_t        out_side
);

	logic             v_s   [DVW+1];
	logic [DVW-1:0]   dd1_s [DVW+1];
	logic [DVW-1:0]   dd2_s [DVW+1];
	logic [DENW-1:0]  rm1_s [DVW+1];
	logic [DENW-1:0]  rm2_s [DVW+1];
	logic [DVW-1:0]   q1_s  [DVW+1];
	logic [DVW-1:0]   q2_s  [DVW+1];
	logic [DENW-1:0]  dn_s  [DVW+1];
	dv_side_t         sd_s  [DVW+1];

	// scale numerators by 2^FB
	assign v_s[0]   = in_valid;
	assign dd1_s[0] = {num1, {FB{1'b0}}};
	assign dd2_s[0] = {num2, {FB{1'b0}}};
	assign rm1_s[0] = '0;
	assign rm2_s[0] = '0;
	assign q1_s[0]  = '0;
	assign q2_s[0]  = '0;
	assign dn_s[0]  = den;
	assign sd_s[0]  = in_side;

	for (genvar k = 0; k < DVW; k++) begin : g_stage
		logic [DENW:0] t1;
		logic [DENW:0] t2;
		logic [DENW:0] d;
		logic          ge1;
		logic          ge2;

		always_comb begin
			d   = {1'b0, dn_s[k]};
			t1  = {rm1_s[k], dd1_s[k][DVW-1]};
			t2  = {rm2_s[k], dd2_s[k][DVW-1]};
			ge1 = (t1 >= d);
			ge2 = (t2 >= d);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dd1_s[k+1] <= dd1_s[k] << 1;
				dd2_s[k+1] <= dd2_s[k] << 1;
				rm1_s[k+1] <= ge1 ? DENW'(t1 - d) : DENW'(t1);
				rm2_s[k+1] <= ge2 ? DENW'(t2 - d) : DENW'(t2);
				q1_s[k+1]  <= {q1_s[k][DVW-2:0], ge1};
				q2_s[k+1]  <= {q2_s[k][DVW-2:0], ge2};
				dn_s[k+1]  <= dn_s[k];
				sd_s[k+1]  <= sd_s[k];
			end
		end
	end

	assign out_valid = v_s[DVW];
	assign quo1      = q1_s[DVW];
	assign quo2      = q2_s[DVW];
	assign out_side  = sd_s[DVW];

endmodule
